// File: hdl/afih_pkg.sv
// Shared types, codes and helpers for the file name id hash unit.
// Holds the reflected CRC-32 byte step, the ASCII case fold and the tail snapshot.
// No dependencies.
package afih_pkg;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic HASH_MODE_ROT = 1'b0;
	localparam logic HASH_MODE_CRC = 1'b1;

	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

	// Open group state of a finished name, handed to the padding tail.
	typedef struct packed {
		logic        mode;
		logic [1:0]  group_pos;
		logic [7:0]  group_first;
		logic [31:0] crc;
		logic [31:0] rot_res;
	} afih_tail_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] fold_upper(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
			r = b - ASCII_CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic [31:0] rotl1(input logic [31:0] v);
		return {v[30:0], v[31]};
	endfunction

endpackage

// File: hdl/archive_filename_id_hash_unit.sv
// Top level of the file name id hash unit: input register, per-byte hash state
// and the hand-off of finished names to the padding tail.
// Depends on afih_pkg and afih_pad_tail.
//
//   channel   handshake             payload
//   cfg       cfg_valid/cfg_ready   cfg_data  (hash_mode, 0 rotate-add, 1 CRC-32)
//   in        in_valid/in_ready     ch, has_char, last
//   out       out_valid/out_ready   id
//
// One beat is taken every cycle while in_ready is high; each byte does one rotate-add
// and one CRC byte step in the state stage. After its last beat is taken into the input
// register, an id passes the count-byte stage, the final pad stage and the output register.
// Reset clears the hash state (CRC to all ones) and selects the rotate-add mode.
// in_ready drops only when every stage behind a pending last beat is full and
// out_ready is low; cfg_ready is always high.
module archive_filename_id_hash_unit import afih_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        has_char,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] id
);

	logic        hash_mode_q;
	logic        v1_q;
	logic [7:0]  ch_s1;
	logic        has_char_s1;
	logic        last_s1;

	logic [31:0] rot_sum_q;
	logic [31:0] word_acc_q;
	logic [1:0]  group_pos_q;
	logic [31:0] crc_q;
	logic [7:0]  group_first_q;

	logic        tail_valid;
	logic        tail_ready;
	afih_tail_t  tail;

	logic        s1_go;
	logic [7:0]  byte_c;
	logic [31:0] word_sel;
	logic [31:0] sum;
	logic        group_done;
	logic [1:0]  group_pos_new;
	logic [31:0] crc_new;
	logic [7:0]  first_new;
	logic [31:0] rot_res;

	assign cfg_ready = 1'b1;

	// A byte that is not last never waits on the tail.
	assign tail_valid = v1_q && last_s1;
	assign s1_go      = v1_q && (!last_s1 || tail_ready);
	assign in_ready   = !v1_q || s1_go;

	always_comb begin
		byte_c        = fold_upper(ch_s1);
		word_sel      = word_acc_q;
		crc_new       = crc_q;
		first_new     = group_first_q;
		group_pos_new = group_pos_q;
		if (has_char_s1) begin
			word_sel      = word_acc_q | ({24'h0, byte_c} << {group_pos_q, 3'b000});
			crc_new       = crc_byte(crc_q, byte_c);
			group_pos_new = group_pos_q + 2'd1;
			if (group_pos_q == 2'd0) begin
				first_new = byte_c;
			end
		end
		group_done = has_char_s1 && (group_pos_q == 2'd3);
		sum        = rotl1(rot_sum_q) + word_sel;
		// An open group counts as a zero-filled word.
		rot_res    = (group_done || group_pos_new != 2'd0) ? sum : rot_sum_q;

		tail.mode        = hash_mode_q;
		tail.group_pos   = group_pos_new;
		tail.group_first = first_new;
		tail.crc         = crc_new;
		tail.rot_res     = rot_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_mode_q   <= HASH_MODE_ROT;
			v1_q          <= 1'b0;
			rot_sum_q     <= '0;
			word_acc_q    <= '0;
			group_pos_q   <= '0;
			crc_q         <= CRC_INIT;
			group_first_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				hash_mode_q <= cfg_data;
			end
			if (in_ready) begin
				v1_q <= in_valid;
			end
			if (s1_go) begin
				if (last_s1) begin
					rot_sum_q     <= '0;
					word_acc_q    <= '0;
					group_pos_q   <= '0;
					crc_q         <= CRC_INIT;
					group_first_q <= '0;
				end else begin
					rot_sum_q     <= group_done ? sum : rot_sum_q;
					word_acc_q    <= group_done ? 32'h0 : word_sel;
					group_pos_q   <= group_pos_new;
					crc_q         <= crc_new;
					group_first_q <= first_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ch_s1       <= ch;
			has_char_s1 <= has_char;
			last_s1     <= last;
		end
	end

	afih_pad_tail u_pad_tail (
		.clk        (clk),
		.arst_n     (arst_n),
		.tail_valid (tail_valid),
		.tail_ready (tail_ready),
		.tail       (tail),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.id         (id)
	);

	// Name state starts over after its last beat leaves the input register.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (group_pos_q == 2'd0 && crc_q == CRC_INIT
			&& rot_sum_q == 32'h0 && word_acc_q == 32'h0))
		else $error("hash state not cleared after last beat");

	// Each byte that is not last advances the group position by one.
	a_group_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && has_char_s1 && !last_s1) |=> (group_pos_q == $past(group_pos_q) + 2'd1))
		else $error("group position did not advance on a byte");

	// A stalled hand-off to the tail keeps its snapshot.
	a_tail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_valid && !tail_ready) |=> (tail_valid && $stable(tail)))
		else $error("tail snapshot changed while stalled");

endmodule

// File: hdl/afih_pad_tail.sv
// Padding tail: appends the remainder count and copies of the group's first byte
// to the CRC, selects the id by mode and holds it in the output register.
// Depends on afih_pkg.
module afih_pad_tail import afih_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tail_valid,
	output logic        tail_ready,
	input  afih_tail_t  tail,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] id
);

	logic        v2_q;
	afih_tail_t  tail_s2;
	logic        v3_q;
	logic [31:0] crc_s3;
	logic [1:0]  group_pos_s3;
	logic [7:0]  group_first_s3;
	logic        mode_s3;
	logic [31:0] rot_res_s3;
	logic        out_valid_q;
	logic [31:0] id_q;

	logic        o_free;
	logic        s3_free;
	logic        s2_free;
	logic [31:0] crc_pad2;
	logic [31:0] crc_pad3;
	logic [31:0] id_next;

	assign o_free     = !out_valid_q || out_ready;
	assign s3_free    = !v3_q || o_free;
	assign s2_free    = !v2_q || s3_free;
	assign tail_ready = s2_free;

	// Count byte, then, when one or two bytes are open, the first copy of the group's first byte.
	always_comb begin
		crc_pad2 = tail_s2.crc;
		if (tail_s2.group_pos != 2'd0) begin
			crc_pad2 = crc_byte(crc_pad2, {6'h00, tail_s2.group_pos});
		end
		if (tail_s2.group_pos == 2'd1 || tail_s2.group_pos == 2'd2) begin
			crc_pad2 = crc_byte(crc_pad2, tail_s2.group_first);
		end
	end

	// A single byte left open needs one more copy.
	always_comb begin
		crc_pad3 = crc_s3;
		if (group_pos_s3 == 2'd1) begin
			crc_pad3 = crc_byte(crc_s3, group_first_s3);
		end
		id_next = (mode_s3 == HASH_MODE_CRC) ? ~crc_pad3 : rot_res_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_q        <= 1'b0;
			v3_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_free) begin
				v2_q <= tail_valid;
			end
			if (s3_free) begin
				v3_q <= v2_q;
			end
			if (o_free) begin
				out_valid_q <= v3_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && tail_valid) begin
			tail_s2 <= tail;
		end
		if (s3_free && v2_q) begin
			crc_s3         <= crc_pad2;
			group_pos_s3   <= tail_s2.group_pos;
			group_first_s3 <= tail_s2.group_first;
			mode_s3        <= tail_s2.mode;
			rot_res_s3     <= tail_s2.rot_res;
		end
		if (o_free && v3_q) begin
			id_q <= id_next;
		end
	end

	assign out_valid = out_valid_q;
	assign id        = id_q;

endmodule

// File: dv/afih_id_checker.sv
`timescale 1ns / 1ps
// Checker for the file name id hash unit: watches the cfg, in and out beats,
// predicts the id of each finished name and compares it with the oldest one waiting.
// Depends on afih_pkg for the mode codes and CRC constants.
module afih_id_checker import afih_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        has_char,
	input  logic        last,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] id,
	output int          pend_cnt,
	output int          err_cnt
);

	logic        mode_q;
	logic [31:0] rot_acc;
	logic [31:0] open_word;
	logic [31:0] crc_run;
	logic [1:0]  fill_cnt;
	logic [7:0]  lead_byte;
	logic [31:0] want_id;
	logic [31:0] id_expected_q[$];
	int          err_total;

	function automatic logic [7:0] upcase(input logic [7:0] b);
		if (b >= ASCII_LOWER_A && b <= ASCII_LOWER_Z) begin
			return b - ASCII_CASE_OFFSET;
		end
		return b;
	endfunction

	function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'd0, b};
		repeat (8) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

	function automatic logic [31:0] rot_left1(input logic [31:0] v);
		return (v << 1) | (v >> 31);
	endfunction

	task automatic clear_hashes();
		rot_acc   = '0;
		open_word = '0;
		crc_run   = CRC_INIT;
		fill_cnt  = '0;
		lead_byte = '0;
	endtask

	// Fold one name beat into both hashes; a last beat closes the name.
	task automatic take_name_beat(input logic [7:0] b, input logic hc, input logic lst);
		logic [7:0]  u;
		logic [31:0] c;
		logic [31:0] res;
		if (hc) begin
			u = upcase(b);
			if (fill_cnt == 2'd0) begin
				lead_byte = u;
			end
			open_word = open_word | ({24'd0, u} << (8 * fill_cnt));
			crc_run = crc_step(crc_run, u);
			if (fill_cnt == 2'd3) begin
				rot_acc = rot_left1(rot_acc) + open_word;
				open_word = '0;
			end
			fill_cnt = fill_cnt + 2'd1;
		end
		if (lst) begin
			if (mode_q == HASH_MODE_ROT) begin
				res = (fill_cnt != 2'd0) ? rot_left1(rot_acc) + open_word : rot_acc;
			end else begin
				c = crc_run;
				// pad a short group: byte count, then copies of its first byte
				if (fill_cnt != 2'd0) begin
					c = crc_step(c, {6'd0, fill_cnt});
					for (int k = fill_cnt; k < 3; k++) begin
						c = crc_step(c, lead_byte);
					end
				end
				res = ~c;
			end
			id_expected_q.push_back(res);
			clear_hashes();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = HASH_MODE_ROT;
			clear_hashes();
			id_expected_q.delete();
			err_total = 0;
			pend_cnt <= 0;
			err_cnt <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				mode_q = cfg_data;
			end
			if (in_valid && in_ready) begin
				take_name_beat(ch, has_char, last);
			end
			if (out_valid && out_ready) begin
				if (id_expected_q.size() == 0) begin
					err_total++;
					$display("%0t: id beat with none expected, expected none, got %08h",
						$time, id);
				end else begin
					want_id = id_expected_q.pop_front();
					if (id !== want_id) begin
						err_total++;
						$display("%0t: id mismatch, expected %08h, got %08h",
							$time, want_id, id);
					end
				end
			end
			pend_cnt <= id_expected_q.size();
			err_cnt <= err_total;
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the file name id hash unit: clock, reset, name stimulus,
// config writes and output backpressure; verdict from afih_id_checker.
// Depends on afih_pkg, archive_filename_id_hash_unit and afih_id_checker.
module tb;
	import afih_pkg::*;

	localparam int LIMIT       = 400000;
	localparam int N_PHASES    = 6;
	localparam int PHASE_ITEMS = 255;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  ch;
	logic        has_char;
	logic        last;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] id;
	int          pend_cnt;
	int          err_cnt;
	int          cyc = 0;
	int          n_items = 0;
	int          phase_end;
	int          name_len;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	archive_filename_id_hash_unit DUT (.*);
	afih_id_checker CHK (.*);

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= LIMIT) begin
			$display("FAIL archive_filename_id_hash_unit");
			$finish;
		end
	end

	// Output side: random ready bursts, one long hold-off on request.
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	task automatic send_beat(input logic [7:0] b, input logic hc, input logic lst);
		in_valid <= 1'b1;
		ch <= b;
		has_char <= hc;
		last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (hc || lst) begin
			n_items++;
		end
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Hold input until every id is out, then let the pipeline settle.
	task automatic wait_ids_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pend_cnt != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] name_byte();
		case ($urandom_range(0, 4))
			0: return ASCII_LOWER_A + 8'($urandom_range(0, 25));
			1: return 8'h41 + 8'($urandom_range(0, 25));   // upper case
			2: return 8'h30 + 8'($urandom_range(0, 9));    // digit
			3: return 8'h2E;                               // dot
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_name(input int len, input bit byteless_end);
		for (int i = 0; i < len; i++) begin
			maybe_gap();
			if ($urandom_range(0, 19) == 0) begin
				send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_beat(name_byte(), 1'b1, (i == len - 1) && !byteless_end);
		end
		if (len == 0 || byteless_end) begin
			maybe_gap();
			send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= 1'b0;
		in_valid <= 1'b0;
		ch <= 8'h00;
		has_char <= 1'b0;
		last <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rotate-add mode out of reset
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(ASCII_LOWER_A, 1'b1, 1'b0);
		send_beat(ASCII_LOWER_Z, 1'b1, 1'b0);
		send_beat(8'h7B, 1'b1, 1'b0);
		send_beat(8'h60, 1'b1, 1'b1);
		send_beat(8'hFF, 1'b1, 1'b1);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'hA5, 1'b0, 1'b0);
		send_beat(8'h80, 1'b1, 1'b0);
		send_beat(8'h5A, 1'b0, 1'b1);
		wait_ids_drained();

		// CRC mode: empty name and every short group length
		write_mode(HASH_MODE_CRC);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h74, 1'b1, 1'b1);
		send_beat(8'h41, 1'b1, 1'b0);
		send_beat(8'h7F, 1'b1, 1'b1);
		send_beat(8'h2E, 1'b1, 1'b0);
		send_beat(8'hC3, 1'b1, 1'b0);
		send_beat(8'h7A, 1'b1, 1'b1);

		// switch mode in the middle of a name
		send_beat(8'h6D, 1'b1, 1'b0);
		send_beat(8'h31, 1'b1, 1'b0);
		wait_ids_drained();
		write_mode(HASH_MODE_ROT);
		send_beat(8'h78, 1'b1, 1'b1);

		for (int p = 0; p < N_PHASES; p++) begin
			wait_ids_drained();
			write_mode((p % 2 == 0) ? HASH_MODE_CRC : HASH_MODE_ROT);
			quiet = (p == N_PHASES - 1);
			if (p == 2) begin
				hold_req = 1'b1;
			end
			phase_end = n_items + PHASE_ITEMS;
			while (n_items < phase_end) begin
				name_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12);
				send_name(name_len, $urandom_range(0, 7) == 0);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pend_cnt != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		@(negedge clk);
		if (err_cnt == 0) begin
			$display("PASS archive_filename_id_hash_unit");
		end else begin
			$display("FAIL archive_filename_id_hash_unit");
		end
		$finish;
	end

endmodule
